// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/nfe_pkg.sv =====
// types and constants of the nor flash emulation store
`timescale 1ns / 1ps
`default_nettype none

package nfe_pkg;

    localparam int SECTOR_BYTES = 4096;
    localparam int SECTOR_COUNT = 2;
    localparam int STORE_BYTES  = SECTOR_BYTES * SECTOR_COUNT;
    localparam int ADDR_W       = $clog2(STORE_BYTES);
    localparam int FIFO_DEPTH   = 2;

    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_ERASE = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] start_address;
        logic [31:0] transfer_length;
        logic [31:0] byte_offset;
        logic [31:0] end_address;
        logic [7:0]  write_data;
    } req_t;

    typedef struct packed {
        logic       status;
        logic [7:0] read_data;
    } rsp_t;

    typedef enum logic [1:0] {
        CMD_READ,
        CMD_WRITE,
        CMD_ERASE,
        CMD_ERROR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] stop_addr;
        logic [7:0]        wdata;
    } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nfe_front.sv =====
// front end: bounds checks and classification of each request item
`timescale 1ns / 1ps
`default_nettype none

module nfe_front
    import nfe_pkg::*;
(
    input  var req_t req,
    output var cmd_t cmd
);

    logic              start_ok;
    logic [32:0]       xfer_sum;
    logic              xfer_ok;
    logic [ADDR_W-1:0] xfer_addr;
    logic              erase_ok;
    logic [ADDR_W-1:0] erase_stop;

    assign start_ok  = req.start_address < 32'(STORE_BYTES);
    assign xfer_sum  = {1'b0, req.start_address} + {1'b0, req.transfer_length};
    assign xfer_ok   = start_ok && (xfer_sum < 33'(STORE_BYTES))
                       && (req.byte_offset < req.transfer_length);
    assign xfer_addr = req.start_address[ADDR_W-1:0] + req.byte_offset[ADDR_W-1:0];
    assign erase_ok  = start_ok && (req.end_address >= req.start_address);
    assign erase_stop = (req.end_address >= 32'(STORE_BYTES))
                        ? ADDR_W'(STORE_BYTES - 1) : req.end_address[ADDR_W-1:0];

    always_comb
    begin
        cmd.kind      = CMD_ERROR;
        cmd.addr      = req.start_address[ADDR_W-1:0];
        cmd.stop_addr = erase_stop;
        cmd.wdata     = req.write_data;
        unique case (req.operation) inside
            OP_READ, OP_WRITE:
            begin
                cmd.addr = xfer_addr;
                if (xfer_ok)
                begin
                    cmd.kind = (req.operation == OP_READ) ? CMD_READ : CMD_WRITE;
                end
            end
            OP_ERASE:
            begin
                if (erase_ok)
                begin
                    cmd.kind = CMD_ERASE;
                end
            end
            default:
            begin
                cmd.kind = CMD_ERROR;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/nfe_cmd_fifo.sv =====
// short command queue between front end and back end
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module nfe_cmd_fifo
    import nfe_pkg::*;
(
    input  var logic clk,
    input  var logic rst_n,
    input  var logic push,
    input  var cmd_t push_cmd,
    output var logic full,
    input  var logic pop,
    output var logic cmd_valid,
    output var cmd_t cmd
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    cmd_t             slot_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(FIFO_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                          : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                          : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `ASSERT_IMPLIES(a_no_push_when_full, push, !full, "push into full command queue")
    `ASSERT_IMPLIES(a_no_pop_when_empty, pop, count_reg != '0, "pop from empty command queue")

endmodule

`default_nettype wire

// ===== hw/rtl/nfe_back.sv =====
// back end: byte memory, read-modify-write and erase sweep
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module nfe_back
    import nfe_pkg::*;
(
    input  var logic clk,
    input  var logic rst_n,
    input  var logic cmd_valid,
    input  var cmd_t cmd,
    output var logic pop,
    output var logic rsp_valid,
    input  var logic rsp_stall,
    output var rsp_t rsp
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RDWAIT = 4'b0010,
        ST_RMW    = 4'b0100,
        ST_ERASE  = 4'b1000
    } back_state_t;

    logic [7:0]        mem [STORE_BYTES];

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;
    logic [ADDR_W-1:0] stop_reg;
    logic [ADDR_W-1:0] stop_next;
    logic [7:0]        wdata_reg;
    logic [7:0]        wdata_next;
    logic [7:0]        rd_data_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    rsp_t              out_item_reg;
    rsp_t              out_item_next;

    logic              out_free;
    logic              mem_rd_en;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [7:0]        mem_wr_data;
    logic [ADDR_W-1:0] addr_inc;

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign pop       = (state_reg == ST_IDLE) && cmd_valid && out_free;
    assign mem_rd_en = pop && ((cmd.kind == CMD_READ) || (cmd.kind == CMD_WRITE));
    assign mem_wr_en = (state_reg == ST_RMW) || (state_reg == ST_ERASE);
    assign mem_wr_addr = addr_reg;
    assign mem_wr_data = (state_reg == ST_RMW) ? (rd_data_reg & wdata_reg) : ERASED_BYTE;
    assign addr_inc  = addr_reg + ADDR_W'(1);

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        stop_next      = stop_reg;
        wdata_next     = wdata_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        out_item_next  = out_item_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    addr_next  = cmd.addr;
                    stop_next  = cmd.stop_addr;
                    wdata_next = cmd.wdata;
                    unique case (cmd.kind)
                        CMD_READ:
                        begin
                            state_next = ST_RDWAIT;
                        end
                        CMD_WRITE:
                        begin
                            state_next = ST_RMW;
                        end
                        CMD_ERASE:
                        begin
                            if (cmd.addr == cmd.stop_addr)
                            begin
                                out_valid_next = 1'b1;
                                out_item_next  = '{status: 1'b0, read_data: 8'd0};
                            end
                            else
                            begin
                                state_next = ST_ERASE;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_item_next  = '{status: 1'b1, read_data: 8'd0};
                        end
                    endcase
                end
            end
            ST_RDWAIT:
            begin
                out_valid_next = 1'b1;
                out_item_next  = '{status: 1'b0, read_data: rd_data_reg};
                state_next     = ST_IDLE;
            end
            ST_RMW:
            begin
                out_valid_next = 1'b1;
                out_item_next  = '{status: 1'b0, read_data: 8'd0};
                state_next     = ST_IDLE;
            end
            ST_ERASE:
            begin
                addr_next = addr_inc;
                if (addr_inc == stop_reg)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = '{status: 1'b0, read_data: 8'd0};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        stop_reg     <= stop_next;
        wdata_reg    <= wdata_next;
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            rd_data_reg <= mem[cmd.addr];
        end
    end

    `ASSERT_IMPLIES(a_busy_output_empty, state_reg != ST_IDLE, !out_valid_reg, "result held while busy")
    `ASSERT_IMPLIES(a_erase_below_stop, state_reg == ST_ERASE, addr_reg < stop_reg, "erase pointer passed stop")

endmodule

`default_nettype wire

// ===== hw/rtl/nor_flash_emulation_store.sv =====
// top level of the nor flash emulation store
// usage:
// requests enter on req_valid / req_stall / req, one item per accepted edge:
//   read byte, write byte (and into stored byte) or erase range to 0xff.
// every request item yields exactly one item on rsp_valid / rsp_stall / rsp
// with a status bit and the read byte, in request order.
// a front end checks bounds and classifies each item into a two-entry
// command queue; req_stall is high only while that queue is full.
// the back end owns a single-port 8192 byte memory and runs one command
// at a time: rejected items and empty erases set their result when taken,
// reads and writes do a memory read, then the result or write-back, and
// an erase of n bytes does one memory write per cycle.
// rsp stays in an output register while rsp_stall is high; the back end
// then takes no new command and the queue fills behind it.
// reset clears the queue and control state; memory content is not cleared
// and a byte must be written or erased before it is read.
`timescale 1ns / 1ps
`default_nettype none

module nor_flash_emulation_store
    import nfe_pkg::*;
(
    input  var logic clk,
    input  var logic rst_n,
    input  var logic req_valid,
    output var logic req_stall,
    input  var req_t req,
    output var logic rsp_valid,
    input  var logic rsp_stall,
    output var rsp_t rsp
);

    cmd_t front_cmd;
    cmd_t queue_cmd;
    logic queue_full;
    logic queue_valid;
    logic queue_pop;
    logic queue_push;

    assign req_stall  = queue_full;
    assign queue_push = req_valid && !queue_full;

    nfe_front u_front (
        .req (req),
        .cmd (front_cmd)
    );

    nfe_cmd_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (queue_push),
        .push_cmd  (front_cmd),
        .full      (queue_full),
        .pop       (queue_pop),
        .cmd_valid (queue_valid),
        .cmd       (queue_cmd)
    );

    nfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_valid),
        .cmd       (queue_cmd),
        .pop       (queue_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench for the nor flash emulation store
`timescale 1ns / 1ps

module testbench;
    import nfe_pkg::*;

    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam int RANDOM_ITEMS = 1600;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_START   = 10000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    req_t pending_requests[$];
    rsp_t expected_responses[$];
    logic [7:0] flash_image [STORE_BYTES];

    int error_count = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_cycle = 0;
    int stall_mode = 0;
    rsp_t want;

    nor_flash_emulation_store dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #2 clk = ~clk;

    // expected response of one item, updating the flash image
    function automatic rsp_t flash_access(req_t r);
        rsp_t result;
        longint unsigned first;
        longint unsigned last;
        longint unsigned addr;
        result.status = 1'b1;
        result.read_data = 8'h00;
        first = r.start_address;
        case (r.operation)
            OP_READ, OP_WRITE:
            begin
                last = first + r.transfer_length;
                if (first < STORE_BYTES && last < STORE_BYTES
                        && r.byte_offset < r.transfer_length)
                begin
                    addr = first + r.byte_offset;
                    if (r.operation == OP_READ)
                    begin
                        result.read_data = flash_image[addr];
                    end
                    else
                    begin
                        flash_image[addr] = flash_image[addr] & r.write_data;
                    end
                    result.status = 1'b0;
                end
            end
            OP_ERASE:
            begin
                if (r.end_address >= r.start_address && first < STORE_BYTES)
                begin
                    last = r.end_address;
                    if (last > STORE_BYTES - 1)
                    begin
                        last = STORE_BYTES - 1;
                    end
                    for (addr = first; addr < last; addr++)
                    begin
                        flash_image[addr] = ERASED_BYTE;
                    end
                    result.status = 1'b0;
                end
            end
            default:
            begin
                result.status = 1'b1;
            end
        endcase
        return result;
    endfunction

    task automatic add_item(logic [1:0] op, logic [31:0] start, logic [31:0] len,
                            logic [31:0] off, logic [31:0] stop, logic [7:0] data);
        req_t r;
        r.operation = op;
        r.start_address = start;
        r.transfer_length = len;
        r.byte_offset = off;
        r.end_address = stop;
        r.write_data = data;
        pending_requests.push_back(r);
    endtask

    // mostly a small window at the bottom and the top of the store
    function automatic int unsigned pick_address();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, STORE_BYTES - 2);
            1, 2: return $urandom_range(STORE_BYTES - 64, STORE_BYTES - 2);
            default: return $urandom_range(0, 127);
        endcase
    endfunction

    task automatic queue_random_item();
        int unsigned kind;
        int unsigned addr;
        int unsigned off;
        int unsigned start;
        int unsigned max_len;
        int unsigned len;
        logic [7:0] data;
        kind = $urandom_range(0, 99);
        data = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom | $urandom | $urandom);
        if (kind < 12)
        begin
            add_item(2'($urandom), $urandom, $urandom, $urandom, $urandom, 8'($urandom));
        end
        else if (kind < 20)
        begin
            start = $urandom_range(0, STORE_BYTES - 1);
            case ($urandom_range(0, 3))
                0: add_item(2'($urandom_range(0, 1)), start, STORE_BYTES - start,
                            0, 0, data);
                1: add_item(2'($urandom_range(0, 1)), start, 8,
                            $urandom_range(8, 40), 0, data);
                2: add_item(OP_ERASE, start + 1, 0, 0, start, data);
                default: add_item(2'($urandom_range(0, 1)), start,
                                  32'hFFFF_FFFF - start + 1 + $urandom_range(0, 64),
                                  0, 0, data);
            endcase
        end
        else if (kind < 36)
        begin
            start = pick_address();
            case ($urandom_range(0, 63))
                0: add_item(OP_ERASE, start, 0, 0, 32'hFFFF_FFFF, data);
                1, 2, 3, 4: add_item(OP_ERASE, start, 0, 0,
                                     start + $urandom_range(0, 1024), data);
                default: add_item(OP_ERASE, start, 0, 0,
                                  start + $urandom_range(0, 24), data);
            endcase
        end
        else
        begin
            addr = pick_address();
            if ($urandom_range(0, 9) == 0)
            begin
                off = $urandom_range(0, addr);
            end
            else
            begin
                off = $urandom_range(0, addr < 16 ? addr : 16);
            end
            start = addr - off;
            max_len = STORE_BYTES - 1 - start;
            if ($urandom_range(0, 1) == 0)
            begin
                len = $urandom_range(off + 1, max_len);
            end
            else
            begin
                len = $urandom_range(off + 1, off + 8 < max_len ? off + 8 : max_len);
            end
            add_item($urandom_range(0, 1) ? OP_READ : OP_WRITE, start, len, off, 0, data);
        end
    endtask

    // request driver: bursts of items with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                expected_responses.push_back(flash_access(req));
            end
            if (!req_valid || !req_stall)
            begin
                if (burst_left == 0 && gap_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    req <= pending_requests.pop_front();
                    req_valid <= 1'b1;
                    burst_left--;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // response stall pattern, with one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_cycle = 0;
            stall_mode = 0;
        end
        else
        begin
            stall_cycle++;
            if (stall_cycle % 256 == 0)
            begin
                stall_mode = $urandom_range(0, 3);
            end
            if (stall_cycle >= HOLD_START && stall_cycle < HOLD_START + HOLD_CYCLES)
            begin
                rsp_stall <= 1'b1;
            end
            else
            begin
                case (stall_mode)
                    0: rsp_stall <= 1'b0;
                    1: rsp_stall <= ($urandom_range(0, 3) == 0);
                    2: rsp_stall <= 1'($urandom_range(0, 1));
                    default: rsp_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // response checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_responses.size() == 0)
            begin
                $error("unexpected response item: status %0d read_data %02h",
                       rsp.status, rsp.read_data);
                error_count++;
            end
            else
            begin
                want = expected_responses.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, rsp.status);
                    error_count++;
                end
                if (rsp.read_data !== want.read_data)
                begin
                    $error("read_data mismatch: expected %02h, actual %02h",
                           want.read_data, rsp.read_data);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL nor_flash_emulation_store");
            $finish;
        end
    end

    initial
    begin
        // whole store erased first so every reachable byte is defined
        add_item(OP_ERASE, 0, 0, 0, 32'hFFFF_FFFF, 8'h00);
        add_item(OP_READ, 0, 1, 0, 0, 8'h00);
        add_item(OP_WRITE, 0, 4, 0, 0, 8'h5A);
        add_item(OP_READ, 0, 4, 0, 0, 8'hFF);
        add_item(OP_WRITE, 0, 2, 0, 0, 8'hA5);
        add_item(OP_READ, 0, 1, 0, 0, 8'h00);
        add_item(OP_WRITE, STORE_BYTES - 2, 1, 0, 0, 8'h00);
        add_item(OP_READ, STORE_BYTES - 2, 1, 0, 0, 8'h00);
        add_item(OP_READ, STORE_BYTES - 1, 0, 0, 0, 8'h00);
        add_item(OP_READ, STORE_BYTES - 1, 1, 0, 0, 8'h00);
        add_item(OP_WRITE, 1, 32'hFFFF_FFFF, 0, 0, 8'hFF);
        add_item(OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 8'hFF);
        add_item(OP_READ, 0, 4, 4, 0, 8'h00);
        add_item(OP_WRITE, 100, 8, 32'hFFFF_FFFF, 0, 8'h00);
        add_item(OP_ERASE, 10, 0, 0, 9, 8'h00);
        add_item(OP_ERASE, 20, 0, 0, 20, 8'h00);
        add_item(OP_ERASE, STORE_BYTES, 0, 0, 9000, 8'h00);
        add_item(OP_ERASE, STORE_BYTES - 1, 0, 0, 32'hFFFF_FFFF, 8'h00);
        add_item(OP_ERASE, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF, 8'h00);
        add_item(OP_ERASE, 0, 0, 0, 8, 8'h00);
        add_item(OP_READ, 3, 5, 4, 0, 8'h00);
        add_item(OP_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 8'hFF);
        add_item(OP_RESERVED, 0, 0, 0, 0, 8'h00);
        add_item(OP_WRITE, 7000, STORE_BYTES - 1 - 7000, STORE_BYTES - 2 - 7000,
                 0, 8'hFF);
        repeat (RANDOM_ITEMS) queue_random_item();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() > 0 || req_valid)
        begin
            @(posedge clk);
        end
        while (expected_responses.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("PASS nor_flash_emulation_store");
        end
        else
        begin
            $display("FAIL nor_flash_emulation_store");
        end
        $finish;
    end

endmodule
